/* rtl/hsv2rgb_pkg.sv */
// Package for the HSV to RGB rainbow converter: register indexes, hue
// section codes, ramp fractions and the 8-bit scaling helper.
// No dependencies.
`default_nettype none

package hsv2rgb_pkg;

  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STRONG_YELLOW = 1'b0,
    REG_HALVE_GREEN   = 1'b1
  } cfg_reg_t;

  // Hue sections, top three hue bits
  typedef enum logic [2:0] {
    SEC_RED    = 3'd0,
    SEC_ORANGE = 3'd1,
    SEC_YELLOW = 3'd2,
    SEC_GREEN  = 3'd3,
    SEC_AQUA   = 3'd4,
    SEC_BLUE   = 3'd5,
    SEC_PURPLE = 3'd6,
    SEC_PINK   = 3'd7
  } sect_t;

  localparam logic [7:0] THIRD_F = 8'(256 / 3);
  localparam logic [7:0] TWOTH_F = 8'((256 * 2) / 3);
  localparam logic [7:0] LVL_85  = 8'd85;
  localparam logic [7:0] LVL_170 = 8'd170;
  localparam logic [7:0] LVL_171 = 8'd171;
  localparam logic [7:0] LVL_MAX = 8'd255;

  // (a * (f + 1)) >> 8; the product stays below 2^16
  function automatic logic [7:0] scale8(input logic [7:0] a, input logic [7:0] f);
    logic [16:0] p;
    p = {9'd0, a} * ({9'd0, f} + 17'd1);
    return p[15:8];
  endfunction

endpackage

`default_nettype wire

/* rtl/hsv_to_rgb_rainbow_core.sv */
// HSV to RGB conversion by the eight-section rainbow mapping.
// Uses hsv2rgb_pkg for codes, fractions and the scaling helper.
// Each input word passes through the stage 1, stage 2 and output registers.
// Throughput: one word per cycle while out_tready is high; the three stages (hue map,
// saturation, value) each hold one 8x9 multiply deep; a stall holds the full stages only.
// Reset (rst_n low, synchronous): pipeline emptied, both mode registers 0.
`default_nettype none

module hsv_to_rgb_rainbow_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [hsv2rgb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic        cfg_wdata,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // hue[7:0], saturation[15:8], brightness[23:16]
  // output stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata   // red[7:0], green[15:8], blue[23:16]
);

  logic strong_yellow_r, halve_green_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strong_yellow_r <= 1'b0;
      halve_green_r   <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (hsv2rgb_pkg::cfg_reg_t'(cfg_index))
        hsv2rgb_pkg::REG_STRONG_YELLOW: strong_yellow_r <= cfg_wdata;
        hsv2rgb_pkg::REG_HALVE_GREEN:   halve_green_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage handshake: a stage loads when it is empty or its word moves on
  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;

  assign en3       = !v3_r || out_tready;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // ---------------- stage 1: hue map, floor and squared value
  logic [7:0] hue, sat, val;
  logic [7:0] ramp, third, twoth;
  logic [7:0] r_h, g_h, b_h;
  logic [7:0] d_sat;

  assign hue   = in_tdata[7:0];
  assign sat   = in_tdata[15:8];
  assign val   = in_tdata[23:16];
  assign ramp  = {hue[4:0], 3'b000};
  assign third = hsv2rgb_pkg::scale8(ramp, hsv2rgb_pkg::THIRD_F);
  assign twoth = hsv2rgb_pkg::scale8(ramp, hsv2rgb_pkg::TWOTH_F);
  assign d_sat = hsv2rgb_pkg::LVL_MAX - sat;

  always_comb begin
    r_h = '0;
    g_h = '0;
    b_h = '0;
    unique case (hsv2rgb_pkg::sect_t'(hue[7:5]))
      hsv2rgb_pkg::SEC_RED: begin
        r_h = hsv2rgb_pkg::LVL_MAX - third;
        g_h = third;
      end
      hsv2rgb_pkg::SEC_ORANGE: begin
        if (strong_yellow_r) begin
          r_h = hsv2rgb_pkg::LVL_170 + third;
          g_h = hsv2rgb_pkg::LVL_85 + twoth;
        end else begin
          r_h = hsv2rgb_pkg::LVL_171;
          g_h = hsv2rgb_pkg::LVL_85 + third;
        end
      end
      hsv2rgb_pkg::SEC_YELLOW: begin
        if (strong_yellow_r) begin
          r_h = hsv2rgb_pkg::LVL_MAX - ramp;
          g_h = hsv2rgb_pkg::LVL_MAX;
        end else begin
          r_h = hsv2rgb_pkg::LVL_171 - twoth;
          g_h = hsv2rgb_pkg::LVL_170 + third;
        end
      end
      hsv2rgb_pkg::SEC_GREEN: begin
        g_h = hsv2rgb_pkg::LVL_MAX - third;
        b_h = third;
      end
      hsv2rgb_pkg::SEC_AQUA: begin
        g_h = hsv2rgb_pkg::LVL_171 - twoth;
        b_h = hsv2rgb_pkg::LVL_85 + twoth;
      end
      hsv2rgb_pkg::SEC_BLUE: begin
        r_h = third;
        b_h = hsv2rgb_pkg::LVL_MAX - third;
      end
      hsv2rgb_pkg::SEC_PURPLE: begin
        r_h = hsv2rgb_pkg::LVL_85 + third;
        b_h = hsv2rgb_pkg::LVL_171 - third;
      end
      hsv2rgb_pkg::SEC_PINK: begin
        r_h = hsv2rgb_pkg::LVL_170 + third;
        b_h = hsv2rgb_pkg::LVL_85 - third;
      end
      default: ;
    endcase
    if (halve_green_r) g_h = {1'b0, g_h[7:1]};
  end

  // video rule: add one when the input is nonzero
  logic [15:0] val_sq;
  logic [7:0]  v_sq;
  assign val_sq = {8'd0, val} * {8'd0, val};
  assign v_sq   = val_sq[15:8] + {7'd0, (val != 8'd0)};

  logic [7:0] r1_r, g1_r, b1_r, sat1_r, floor1_r, v1sq_r;
  logic       val_full1_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      r1_r        <= r_h;
      g1_r        <= g_h;
      b1_r        <= b_h;
      sat1_r      <= sat;
      floor1_r    <= hsv2rgb_pkg::scale8(d_sat, d_sat);
      v1sq_r      <= v_sq;
      val_full1_r <= (val == hsv2rgb_pkg::LVL_MAX);
    end
  end

  // ---------------- stage 2: saturation
  // scaling a zero channel gives zero, so no zero test is needed
  logic [7:0] r_s, g_s, b_s;

  always_comb begin
    if (sat1_r == hsv2rgb_pkg::LVL_MAX) begin
      r_s = r1_r;
      g_s = g1_r;
      b_s = b1_r;
    end else if (sat1_r == 8'd0) begin
      r_s = hsv2rgb_pkg::LVL_MAX;
      g_s = hsv2rgb_pkg::LVL_MAX;
      b_s = hsv2rgb_pkg::LVL_MAX;
    end else begin
      r_s = hsv2rgb_pkg::scale8(r1_r, sat1_r) + floor1_r;
      g_s = hsv2rgb_pkg::scale8(g1_r, sat1_r) + floor1_r;
      b_s = hsv2rgb_pkg::scale8(b1_r, sat1_r) + floor1_r;
    end
  end

  logic [7:0] r2_r, g2_r, b2_r, v2sq_r;
  logic       val_full2_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      r2_r        <= r_s;
      g2_r        <= g_s;
      b2_r        <= b_s;
      v2sq_r      <= v1sq_r;
      val_full2_r <= val_full1_r;
    end
  end

  // ---------------- stage 3: brightness, output register
  logic [7:0] r_v, g_v, b_v;

  always_comb begin
    if (val_full2_r) begin
      r_v = r2_r;
      g_v = g2_r;
      b_v = b2_r;
    end else if (v2sq_r == 8'd0) begin
      r_v = '0;
      g_v = '0;
      b_v = '0;
    end else begin
      r_v = hsv2rgb_pkg::scale8(r2_r, v2sq_r);
      g_v = hsv2rgb_pkg::scale8(g2_r, v2sq_r);
      b_v = hsv2rgb_pkg::scale8(b2_r, v2sq_r);
    end
  end

  logic [23:0] out_data_r;

  always_ff @(posedge clk) begin
    if (en3) out_data_r <= {b_v, g_v, r_v};
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
